@@ rtl/salc_pkg.sv @@
// Shared types and codes of the size-aware LRU object cache.
// No dependencies; used by salc_ram.sv and size_aware_lru_cache_with_pins.sv.
package salc_pkg;

    typedef enum logic [1:0] {
        ACT_LOOKUP  = 2'd0,
        ACT_INSERT  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_HIT          = 4'd0,
        ST_INSERTED     = 4'd1,
        ST_TOO_BIG      = 4'd2,
        ST_NO_ROOM      = 4'd3,
        ST_TABLE_FULL   = 4'd4,
        ST_RELEASED     = 4'd5,
        ST_RELEASE_MISS = 4'd6,
        ST_EVICTED      = 4'd7,
        ST_CACHE_OFF    = 4'd8
    } t_status;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned SIZE_W = 32;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } t_slot;

endpackage

@@ rtl/salc_ram.sv @@
// Simple dual-port synchronous RAM with one write and one registered read port.
// Uses salc_pkg only for the common import convention.
module salc_ram
    import salc_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/size_aware_lru_cache_with_pins.sv @@
// Size-aware LRU object cache with pin counts; one item is worked on at a time.
// Steps: a lookup or release makes one pass over the recency list of n entries through
// the registered memory read chain; a hit or an insert adds a rebuild pass; an insert that
// evicts also adds a victim scan, then S_EV_A, S_EV_B and S_EV_C per rank for reporting
// and S_PICK to pick the free slot; eviction reports can be held by output stalls.
// Reset is synchronous and clears valid bits, pins, byte count and budget; no sweep.
// The next transfer is taken the cycle after the final result.
module size_aware_lru_cache_with_pins
    import salc_pkg::*;
#(
    parameter int unsigned ENTRIES  = 32,
    parameter int unsigned PIN_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_object_key,
    input  logic [31:0] i_object_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [31:0] o_evicted_key,
    output logic [31:0] o_evicted_size,
    output logic [31:0] o_bytes_in_use,
    output logic        o_last
);

    localparam int unsigned IDXW = $clog2(ENTRIES);
    localparam int unsigned CW   = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_DEC, S_VSCAN, S_EV_A, S_EV_B, S_EV_C, S_PICK, S_REB, S_FRONT,
        S_OUT
    } t_state;

    t_state r_state;

    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  r_mark;
    logic [PIN_BITS-1:0] r_pins [ENTRIES];
    logic [CW-1:0]       r_n;
    logic [31:0]         r_used;
    logic [31:0]         r_cap;

    t_action             r_action;
    logic [31:0]         r_key;
    logic [31:0]         r_size;

    logic [CW-1:0]       r_rd;
    logic [CW-1:0]       r_left;
    logic [CW-1:0]       r_w;
    logic                r_p1;
    logic                r_p2;
    logic [IDXW-1:0]     r_p2_slot;
    logic                r_found;
    logic [IDXW-1:0]     r_hit_slot;
    logic [32:0]         r_total;
    logic                r_any_victim;
    logic [IDXW-1:0]     r_front;
    logic                r_ins;
    t_status             r_status;

    logic                r_o_valid;
    logic [3:0]          r_o_status;
    logic [31:0]         r_o_key;
    logic [31:0]         r_o_size;
    logic [31:0]         r_o_bytes;
    logic                r_o_last;

    logic                ord_we;
    logic [IDXW-1:0]     ord_wa;
    logic [IDXW-1:0]     ord_wd;
    logic [IDXW-1:0]     ord_q;
    logic                slot_we;
    logic [IDXW-1:0]     slot_ra;
    logic [$bits(t_slot)-1:0] slot_raw;
    t_slot               slot_q;
    t_slot               slot_wd;

    logic [IDXW-1:0]     free_idx;
    logic                can_load;
    logic                out_load;
    logic                pipe_done;
    logic                fits;
    logic [31:0]         used_drop;
    logic [32:0]         used_sum;

    // Recency list: entry at rank r holds the slot number of the r-th most recent object.
    salc_ram #(.DEPTH(ENTRIES), .WIDTH(IDXW)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_wa),
        .i_wdata (ord_wd),
        .i_raddr (r_rd[IDXW-1:0]),
        .o_rdata (ord_q)
    );

    salc_ram #(.DEPTH(ENTRIES), .WIDTH($bits(t_slot))) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_front),
        .i_wdata (slot_wd),
        .i_raddr (slot_ra),
        .o_rdata (slot_raw)
    );

    assign slot_q       = t_slot'(slot_raw);
    assign slot_wd.key  = r_key;
    assign slot_wd.size = r_size;

    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDXW'(i);
            end
        end
    end

    // The rebuild pass compacts the list upward while reading ahead of the writes.
    always_comb begin
        ord_we  = 1'b0;
        ord_wa  = r_w[IDXW-1:0];
        ord_wd  = ord_q;
        if (r_state == S_REB && r_p1 && !r_mark[ord_q]) begin
            ord_we = 1'b1;
        end else if (r_state == S_FRONT) begin
            ord_we = 1'b1;
            ord_wa = '0;
            ord_wd = r_front;
        end
        slot_we = (r_state == S_FRONT) && r_ins;
        slot_ra = (r_state == S_EV_B || r_p1) ? ord_q : r_p2_slot;
    end

    assign can_load  = !r_o_valid || !i_stall;
    assign out_load  = can_load && ((r_state == S_OUT)
                                    || (r_state == S_EV_C && r_mark[r_p2_slot]));
    assign pipe_done = (r_left == '0) && !r_p1 && !r_p2;
    assign fits      = (r_used <= r_cap) && (r_size <= r_cap - r_used);
    assign used_drop = (slot_q.size <= r_used) ? r_used - slot_q.size : '0;
    assign used_sum  = {1'b0, r_used} + {1'b0, r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_mark    <= '0;
            r_n       <= '0;
            r_used    <= '0;
            r_cap     <= '0;
            r_p1      <= 1'b0;
            r_p2      <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_pins[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (r_o_valid && !i_stall && !out_load) begin
                r_o_valid <= 1'b0;
            end

            // Shared two-stage read pipeline for the list passes.
            r_p2      <= r_p1;
            r_p2_slot <= ord_q;
            if ((r_state == S_FIND || r_state == S_VSCAN || r_state == S_REB)
                    && r_left != '0) begin
                r_p1   <= 1'b1;
                r_left <= r_left - CW'(1);
                r_rd   <= (r_state == S_VSCAN) ? r_rd - CW'(1) : r_rd + CW'(1);
            end else begin
                r_p1 <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= t_action'(i_action);
                        r_key    <= i_object_key;
                        r_size   <= i_object_size;
                        if (t_action'(i_action) == ACT_NONE) begin
                            r_state <= S_IDLE;
                        end else if (r_cap == '0) begin
                            r_status <= ST_CACHE_OFF;
                            r_state  <= S_OUT;
                        end else begin
                            r_rd    <= '0;
                            r_left  <= r_n;
                            r_found <= 1'b0;
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (r_p2 && slot_q.key == r_key) begin
                        r_found    <= 1'b1;
                        r_hit_slot <= r_p2_slot;
                    end
                    if (pipe_done) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_found && r_action != ACT_RELEASE) begin
                        if (r_pins[r_hit_slot] != '1) begin
                            r_pins[r_hit_slot] <= r_pins[r_hit_slot] + PIN_BITS'(1);
                        end
                        r_mark[r_hit_slot] <= 1'b1;
                        r_front  <= r_hit_slot;
                        r_ins    <= 1'b0;
                        r_status <= ST_HIT;
                        r_rd     <= '0;
                        r_left   <= r_n;
                        r_w      <= CW'(1);
                        r_state  <= S_REB;
                    end else if (r_action == ACT_RELEASE) begin
                        if (r_found) begin
                            if (r_pins[r_hit_slot] != '0) begin
                                r_pins[r_hit_slot] <= r_pins[r_hit_slot] - PIN_BITS'(1);
                            end
                            r_status <= ST_RELEASED;
                        end else begin
                            r_status <= ST_RELEASE_MISS;
                        end
                        r_state <= S_OUT;
                    end else if (r_action == ACT_LOOKUP) begin
                        r_status <= ST_RELEASE_MISS;
                        r_state  <= S_OUT;
                    end else if (r_size > r_cap) begin
                        r_status <= ST_TOO_BIG;
                        r_state  <= S_OUT;
                    end else if (fits) begin
                        if (r_n == CW'(ENTRIES)) begin
                            r_status <= ST_TABLE_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_front  <= free_idx;
                            r_ins    <= 1'b1;
                            r_status <= ST_INSERTED;
                            r_rd     <= '0;
                            r_left   <= r_n;
                            r_w      <= CW'(1);
                            r_state  <= S_REB;
                        end
                    end else begin
                        r_rd         <= r_n - CW'(1);
                        r_left       <= r_n;
                        r_total      <= '0;
                        r_any_victim <= 1'b0;
                        r_state      <= S_VSCAN;
                    end
                end
                S_VSCAN: begin
                    // Victims are taken from the least recent end until the sizes cover
                    // the new object; later reads in flight are ignored.
                    if (r_p2 && r_total < {1'b0, r_size} && r_pins[r_p2_slot] == '0) begin
                        r_mark[r_p2_slot] <= 1'b1;
                        r_total           <= r_total + {1'b0, slot_q.size};
                        r_any_victim      <= 1'b1;
                    end
                    if (pipe_done) begin
                        if (r_total < {1'b0, r_size}) begin
                            r_mark   <= '0;
                            r_status <= ST_NO_ROOM;
                            r_state  <= S_OUT;
                        end else if (r_any_victim) begin
                            r_rd    <= r_n - CW'(1);
                            r_left  <= r_n;
                            r_state <= S_EV_A;
                        end else if (r_n == CW'(ENTRIES)) begin
                            r_status <= ST_TABLE_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_front  <= free_idx;
                            r_ins    <= 1'b1;
                            r_status <= ST_INSERTED;
                            r_rd     <= '0;
                            r_left   <= r_n;
                            r_w      <= CW'(1);
                            r_state  <= S_REB;
                        end
                    end
                end
                S_EV_A: begin
                    r_state <= S_EV_B;
                end
                S_EV_B: begin
                    r_state <= S_EV_C;
                end
                S_EV_C: begin
                    if (!r_mark[r_p2_slot] || can_load) begin
                        if (r_mark[r_p2_slot]) begin
                            r_o_valid  <= 1'b1;
                            r_o_status <= ST_EVICTED;
                            r_o_key    <= slot_q.key;
                            r_o_size   <= slot_q.size;
                            r_o_bytes  <= used_drop;
                            r_o_last   <= 1'b0;
                            r_used     <= used_drop;
                            r_valid[r_p2_slot] <= 1'b0;
                            r_pins[r_p2_slot]  <= '0;
                        end
                        r_left <= r_left - CW'(1);
                        r_rd   <= r_rd - CW'(1);
                        if (r_left == CW'(1)) begin
                            r_state <= S_PICK;
                        end else begin
                            r_state <= S_EV_A;
                        end
                    end
                end
                S_PICK: begin
                    // The victims have left the table, so the lowest free slot is settled.
                    r_front  <= free_idx;
                    r_ins    <= 1'b1;
                    r_status <= ST_INSERTED;
                    r_rd     <= '0;
                    r_left   <= r_n;
                    r_w      <= CW'(1);
                    r_state  <= S_REB;
                end
                S_REB: begin
                    if (r_p1 && !r_mark[ord_q]) begin
                        r_w <= r_w + CW'(1);
                    end
                    if (pipe_done) begin
                        r_state <= S_FRONT;
                    end
                end
                S_FRONT: begin
                    r_mark <= '0;
                    r_n    <= r_w;
                    if (r_ins) begin
                        r_valid[r_front] <= 1'b1;
                        r_pins[r_front]  <= PIN_BITS'(1);
                        r_used <= used_sum[32] ? '1 : used_sum[31:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (can_load) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_key    <= '0;
                        r_o_size   <= '0;
                        r_o_bytes  <= r_used;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_evicted_key  = r_o_key;
    assign o_evicted_size = r_o_size;
    assign o_bytes_in_use = r_o_bytes;
    assign o_last         = r_o_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(ENTRIES))
        else $error("entry count exceeds table size");

    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_valid) == int'(r_n)))
        else $error("valid bits disagree with entry count");

    a_marks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_mark == '0))
        else $error("victim marks left set after an item");
`endif

endmodule
